// ===== rtl/pfe_pkg.sv =====
// Shared types, constants and codes for the postfix expression evaluator.
// Used by pfe_ctrl, pfe_datapath and postfix_expression_evaluator_top.
package pfe_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int FILL_W      = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int STATUS_W    = 3;
    localparam int DIGIT_W     = 4;
    localparam int SYM_W       = 8;
    localparam int CNT_W       = $clog2(DATA_W);

    localparam logic [SYM_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [SYM_W-1:0] CH_NINE  = 8'h39;
    localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [SYM_W-1:0] CH_CARET = 8'h5E;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DIVZERO   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_POW
    } op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              push;        // load a digit into the top-of-stack register
        logic              push_spill;  // old top moves down into the stack memory
        logic [ADDR_W-1:0] wr_addr;
        logic [DIGIT_W-1:0] digit;
        logic [ADDR_W-1:0] rd_addr;     // address of the second entry from the top
        logic              exec;        // apply op to top and second entry
        op_t               op;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic              busy;        // iterative divide or power in progress
        logic              a_zero;      // top of stack is zero
        logic [DATA_W-1:0] tos;
    } dp_stat_t;

endpackage

// ===== rtl/pfe_datapath.sv =====
// Datapath: top-of-stack register, operand stack memory and the arithmetic units
// (add, subtract, multiply, iterative divide, square-and-multiply power). Uses pfe_pkg.
module pfe_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  pfe_pkg::dp_cmd_t  cmd,
    output pfe_pkg::dp_stat_t stat
);

    localparam int DW = pfe_pkg::DATA_W;

    logic [DW-1:0] mem [pfe_pkg::STACK_DEPTH];
    logic [DW-1:0] rd_data_reg;

    logic [DW-1:0] tos_reg,   tos_next;
    logic [DW-1:0] rem_reg,   rem_next;
    logic [DW-1:0] quot_reg,  quot_next;
    logic [DW-1:0] md_reg,    md_next;
    logic          neg_reg,   neg_next;
    logic [DW-1:0] acc_reg,   acc_next;
    logic [DW-1:0] base_reg,  base_next;
    logic [DW-1:0] expo_reg,  expo_next;
    logic [pfe_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic          busy_reg,  busy_next;
    logic          is_pow_reg, is_pow_next;

    logic [DW-1:0] op_a, op_b, a_mag, b_mag;
    logic [DW-1:0] mul_x, mul_y, prod, sq;
    logic [DW:0]   rem_sh;
    logic [DW+1:0] trial;
    logic          q_bit;
    logic [DW-1:0] rem_new, quot_new;
    logic [DW-1:0] neg_pow;

    always_ff @(posedge aclk) begin
        if (cmd.push && cmd.push_spill) begin
            mem[cmd.wr_addr] <= tos_reg;
        end
        rd_data_reg <= mem[cmd.rd_addr];
    end

    assign op_a  = tos_reg;
    assign op_b  = rd_data_reg;
    assign a_mag = op_a[DW-1] ? (~op_a + 1'b1) : op_a;
    assign b_mag = op_b[DW-1] ? (~op_b + 1'b1) : op_b;

    // One multiplier shared by the multiply operator and the power accumulator.
    assign mul_x = busy_reg ? acc_reg  : op_b;
    assign mul_y = busy_reg ? base_reg : op_a;
    assign prod  = mul_x * mul_y;
    assign sq    = base_reg * base_reg;

    // One restoring division step per cycle on the magnitudes.
    assign rem_sh   = {rem_reg, quot_reg[DW-1]};
    assign trial    = {1'b0, rem_sh} - {2'b00, md_reg};
    assign q_bit    = ~trial[DW+1];
    assign rem_new  = q_bit ? trial[DW-1:0] : rem_sh[DW-1:0];
    assign quot_new = {quot_reg[DW-2:0], q_bit};

    // Negative exponent: only bases of one and minus one survive.
    always_comb begin
        if (op_b == DW'(1)) begin
            neg_pow = DW'(1);
        end else if (op_b == '1) begin
            neg_pow = op_a[0] ? '1 : DW'(1);
        end else begin
            neg_pow = '0;
        end
    end

    always_comb begin
        tos_next    = tos_reg;
        rem_next    = rem_reg;
        quot_next   = quot_reg;
        md_next     = md_reg;
        neg_next    = neg_reg;
        acc_next    = acc_reg;
        base_next   = base_reg;
        expo_next   = expo_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        is_pow_next = is_pow_reg;

        if (busy_reg) begin
            if (is_pow_reg) begin
                if (expo_reg == '0) begin
                    tos_next  = acc_reg;
                    busy_next = 1'b0;
                end else begin
                    acc_next  = expo_reg[0] ? prod : acc_reg;
                    base_next = sq;
                    expo_next = expo_reg >> 1;
                end
            end else begin
                rem_next  = rem_new;
                quot_next = quot_new;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == pfe_pkg::CNT_W'(DW - 1)) begin
                    tos_next  = neg_reg ? (~quot_new + 1'b1) : quot_new;
                    busy_next = 1'b0;
                end
            end
        end else if (cmd.exec) begin
            case (cmd.op)
                pfe_pkg::OP_ADD: tos_next = op_b + op_a;
                pfe_pkg::OP_SUB: tos_next = op_b - op_a;
                pfe_pkg::OP_MUL: tos_next = prod;
                pfe_pkg::OP_DIV: begin
                    if (op_a == '0) begin
                        tos_next = '0;
                    end else begin
                        rem_next    = '0;
                        quot_next   = b_mag;
                        md_next     = a_mag;
                        neg_next    = op_a[DW-1] ^ op_b[DW-1];
                        cnt_next    = '0;
                        busy_next   = 1'b1;
                        is_pow_next = 1'b0;
                    end
                end
                default: begin
                    if (op_a[DW-1]) begin
                        tos_next = neg_pow;
                    end else begin
                        acc_next    = DW'(1);
                        base_next   = op_b;
                        expo_next   = op_a;
                        busy_next   = 1'b1;
                        is_pow_next = 1'b1;
                    end
                end
            endcase
        end else if (cmd.push) begin
            tos_next = DW'(cmd.digit);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            is_pow_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            busy_reg   <= busy_next;
            is_pow_reg <= is_pow_next;
            cnt_reg    <= cnt_next;
        end
        tos_reg  <= tos_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        md_reg   <= md_next;
        neg_reg  <= neg_next;
        acc_reg  <= acc_next;
        base_reg <= base_next;
        expo_reg <= expo_next;
    end

    assign stat.busy   = busy_reg;
    assign stat.a_zero = (tos_reg == '0);
    assign stat.tos    = tos_reg;

endmodule

// ===== rtl/pfe_ctrl.sv =====
// Controller: symbol decode, stack fill count, sticky error code, sequencing
// and the result output register. Uses pfe_pkg; drives pfe_datapath.
module pfe_ctrl (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [pfe_pkg::SYM_W-1:0]           s_symbol,
    input  logic                                s_end_of_expr,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [pfe_pkg::DATA_W-1:0]   m_value,
    output logic [pfe_pkg::STATUS_W-1:0]        m_status,
    output pfe_pkg::dp_cmd_t                    cmd,
    input  pfe_pkg::dp_stat_t                   stat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WAIT,
        S_EMIT
    } state_t;

    localparam logic [pfe_pkg::FILL_W-1:0] FULL = pfe_pkg::FILL_W'(pfe_pkg::STACK_DEPTH);

    state_t                          state_reg,  state_next;
    logic [pfe_pkg::FILL_W-1:0]      fill_reg,   fill_next;
    logic [pfe_pkg::STATUS_W-1:0]    err_reg,    err_next;
    logic                            last_reg,   last_next;
    pfe_pkg::op_t                    op_reg,     op_next;
    logic                            mv_reg,     mv_next;
    logic [pfe_pkg::DATA_W-1:0]      mval_reg,   mval_next;
    logic [pfe_pkg::STATUS_W-1:0]    mst_reg,    mst_next;

    logic         is_digit, is_op, accept;
    pfe_pkg::op_t op_dec;
    logic [pfe_pkg::SYM_W-1:0] digit_full;

    always_comb begin
        is_op  = 1'b1;
        op_dec = pfe_pkg::OP_ADD;
        unique case (s_symbol)
            pfe_pkg::CH_PLUS:  op_dec = pfe_pkg::OP_ADD;
            pfe_pkg::CH_MINUS: op_dec = pfe_pkg::OP_SUB;
            pfe_pkg::CH_STAR:  op_dec = pfe_pkg::OP_MUL;
            pfe_pkg::CH_SLASH: op_dec = pfe_pkg::OP_DIV;
            pfe_pkg::CH_CARET: op_dec = pfe_pkg::OP_POW;
            default:           is_op  = 1'b0;
        endcase
    end

    assign is_digit   = (s_symbol >= pfe_pkg::CH_ZERO) && (s_symbol <= pfe_pkg::CH_NINE);
    assign digit_full = s_symbol - pfe_pkg::CH_ZERO;
    assign s_ready    = (state_reg == S_IDLE);
    assign accept     = s_valid && s_ready;

    assign cmd.push       = accept && is_digit && (fill_reg != FULL);
    assign cmd.push_spill = (fill_reg != '0);
    assign cmd.wr_addr    = pfe_pkg::ADDR_W'(fill_reg - 1'b1);
    assign cmd.digit      = digit_full[pfe_pkg::DIGIT_W-1:0];
    assign cmd.rd_addr    = pfe_pkg::ADDR_W'(fill_reg - 2'd2);
    assign cmd.exec       = (state_reg == S_EXEC);
    assign cmd.op         = op_reg;

    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        err_next   = err_reg;
        last_next  = last_reg;
        op_next    = op_reg;
        mv_next    = mv_reg && !m_ready;
        mval_next  = mval_reg;
        mst_next   = mst_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    last_next  = s_end_of_expr;
                    state_next = s_end_of_expr ? S_EMIT : S_IDLE;
                    if (is_op) begin
                        if (fill_reg < pfe_pkg::FILL_W'(2)) begin
                            if (err_reg == pfe_pkg::ST_OK) begin
                                err_next = pfe_pkg::ST_UNDERFLOW;
                            end
                        end else begin
                            op_next    = op_dec;
                            state_next = S_EXEC;
                        end
                    end else if (is_digit) begin
                        if (fill_reg == FULL) begin
                            if (err_reg == pfe_pkg::ST_OK) begin
                                err_next = pfe_pkg::ST_OVERFLOW;
                            end
                        end else begin
                            fill_next = fill_reg + 1'b1;
                        end
                    end
                end
            end
            S_EXEC: begin
                fill_next = fill_reg - 1'b1;
                if (op_reg == pfe_pkg::OP_DIV && stat.a_zero && err_reg == pfe_pkg::ST_OK) begin
                    err_next = pfe_pkg::ST_DIVZERO;
                end
                state_next = S_WAIT;
            end
            S_WAIT: begin
                if (!stat.busy) begin
                    state_next = last_reg ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT: begin
                if (!mv_reg || m_ready) begin
                    mv_next   = 1'b1;
                    mval_next = (fill_reg != '0) ? stat.tos : '0;
                    if (err_reg != pfe_pkg::ST_OK) begin
                        mst_next = err_reg;
                    end else if (fill_reg == '0) begin
                        mst_next = pfe_pkg::ST_EMPTY;
                    end else begin
                        mst_next = pfe_pkg::ST_OK;
                    end
                    fill_next  = '0;
                    err_next   = pfe_pkg::ST_OK;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            err_reg   <= pfe_pkg::ST_OK;
            last_reg  <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            err_reg   <= err_next;
            last_reg  <= last_next;
            mv_reg    <= mv_next;
        end
        op_reg   <= op_next;
        mval_reg <= mval_next;
        mst_reg  <= mst_next;
    end

    assign m_valid  = mv_reg;
    assign m_value  = mval_reg;
    assign m_status = mst_reg;

endmodule

// ===== rtl/postfix_expression_evaluator_top.sv =====
// Postfix expression evaluator: one character per transaction, 32-bit wrapping integers.
// A digit or ignored character is handled as it is accepted; an operator goes through an
// execute and a wait state, in which / runs one restoring step per cycle over 32 quotient
// bits and ^ one square-and-multiply step per exponent bit. The character marked last also
// loads the result register. Characters are taken one at a time.
// Synchronous active-low reset (aresetn) empties the stack, clears the error and m_valid.
module postfix_expression_evaluator_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [pfe_pkg::SYM_W-1:0]           s_symbol,
    input  logic                                s_end_of_expr,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [pfe_pkg::DATA_W-1:0]   m_value,
    output logic [pfe_pkg::STATUS_W-1:0]        m_status
);

    // The controller owns the fill count, the first-error code and the result register.
    // The datapath keeps the top of the stack in a register and the entries below it in a
    // small memory, so an operator needs only one memory read, for the second entry.
    pfe_pkg::dp_cmd_t  dp_cmd;
    pfe_pkg::dp_stat_t dp_stat;

    pfe_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_symbol      (s_symbol),
        .s_end_of_expr (s_end_of_expr),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_value       (m_value),
        .m_status      (m_status),
        .cmd           (dp_cmd),
        .stat          (dp_stat)
    );

    // The divide and power units run here while the controller waits on the busy flag.
    pfe_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (dp_cmd),
        .stat    (dp_stat)
    );

    // No new transaction may be taken while an iterative unit is still working.
    a_no_accept_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_stat.busy |-> !s_ready)
        else $error("input accepted while the arithmetic unit is busy");

    // An operator is applied in the cycle after its transaction was accepted.
    a_exec_follows_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.exec |-> $past(s_valid && s_ready))
        else $error("operator executed without a preceding input transaction");

    // A digit is pushed only in the cycle its transaction is accepted.
    a_push_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.push |-> (s_valid && s_ready))
        else $error("digit pushed outside an input transaction");

    // The result status is always one of the defined codes.
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == pfe_pkg::ST_OK || m_status == pfe_pkg::ST_UNDERFLOW ||
                     m_status == pfe_pkg::ST_OVERFLOW || m_status == pfe_pkg::ST_DIVZERO ||
                     m_status == pfe_pkg::ST_EMPTY))
        else $error("undefined result status code");

endmodule

// ===== bench/tb_postfix_expression_evaluator_top.sv =====
// Self-checking testbench for postfix_expression_evaluator_top: directed and random
// postfix expressions, checked against a predictor that runs in the bench itself.
// Depends on pfe_pkg and the evaluator RTL only.
module tb_postfix_expression_evaluator_top;

    timeunit 1ns;
    timeprecision 1ps;

    // The clock, the reset and both channels of the block.
    logic                                aclk;
    logic                                aresetn;
    logic                                s_valid;
    logic                                s_ready;
    logic [pfe_pkg::SYM_W-1:0]           s_symbol;
    logic                                s_end_of_expr;
    logic                                m_valid;
    logic                                m_ready;
    logic signed [pfe_pkg::DATA_W-1:0]   m_value;
    logic [pfe_pkg::STATUS_W-1:0]        m_status;

    // One expected result: the top of the stack and the status code.
    typedef struct {
        logic signed [pfe_pkg::DATA_W-1:0] value;
        logic [pfe_pkg::STATUS_W-1:0]      status;
    } expr_result_t;

    // The bench keeps its own copy of the operand stack, its fill level and the first
    // error of the expression in progress. Results still to come wait in a queue.
    logic [pfe_pkg::DATA_W-1:0]   shadow_stack [pfe_pkg::STACK_DEPTH];
    int                           shadow_fill;
    logic [pfe_pkg::STATUS_W-1:0] shadow_error;
    expr_result_t                 pending_results [$];

    // Idle and stall rates, in cycles per hundred, of the current phase.
    int send_idle_pct;
    int recv_stall_pct;

    // Tallies for the closing summary, and the failure count.
    int symbols_sent;
    int results_seen;
    int status_seen [5];
    int fail_count;

    postfix_expression_evaluator_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_symbol      (s_symbol),
        .s_end_of_expr (s_end_of_expr),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_value       (m_value),
        .m_status      (m_status)
    );

    // A 10 ns clock.
    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Classification and arithmetic of the predictor
    // ------------------------------------------------------------------

    function automatic bit is_digit(input logic [pfe_pkg::SYM_W-1:0] sym);
        return sym >= pfe_pkg::CH_ZERO && sym <= pfe_pkg::CH_NINE;
    endfunction

    function automatic bit is_operator(input logic [pfe_pkg::SYM_W-1:0] sym);
        return sym == pfe_pkg::CH_PLUS || sym == pfe_pkg::CH_MINUS ||
               sym == pfe_pkg::CH_STAR || sym == pfe_pkg::CH_SLASH ||
               sym == pfe_pkg::CH_CARET;
    endfunction

    // Quotient truncated towards zero. The most negative value divided by minus one
    // wraps back to itself, which the unsigned magnitudes give for free.
    function automatic logic [pfe_pkg::DATA_W-1:0] quotient_trunc(
        input logic [pfe_pkg::DATA_W-1:0] num,
        input logic [pfe_pkg::DATA_W-1:0] den);
        logic [pfe_pkg::DATA_W-1:0] mag_num;
        logic [pfe_pkg::DATA_W-1:0] mag_den;
        logic [pfe_pkg::DATA_W-1:0] quot;
        mag_num = num[pfe_pkg::DATA_W-1] ? (32'd0 - num) : num;
        mag_den = den[pfe_pkg::DATA_W-1] ? (32'd0 - den) : den;
        quot    = mag_num / mag_den;
        return (num[pfe_pkg::DATA_W-1] ^ den[pfe_pkg::DATA_W-1]) ? (32'd0 - quot) : quot;
    endfunction

    // Integer power with wrapping products. A negative exponent leaves only the bases
    // one and minus one with a non-zero result.
    function automatic logic [pfe_pkg::DATA_W-1:0] power_wrap(
        input logic [pfe_pkg::DATA_W-1:0] base,
        input logic [pfe_pkg::DATA_W-1:0] expo);
        logic [pfe_pkg::DATA_W-1:0] acc;
        logic [pfe_pkg::DATA_W-1:0] sq;
        logic [pfe_pkg::DATA_W-1:0] rest;
        acc  = 32'd1;
        sq   = base;
        rest = expo;
        if (expo[pfe_pkg::DATA_W-1]) begin
            if (base == 32'd1)
                return 32'd1;
            if (base == 32'hFFFF_FFFF)
                return expo[0] ? 32'hFFFF_FFFF : 32'd1;
            return 32'd0;
        end
        while (rest != 0) begin
            if (rest[0])
                acc = acc * sq;
            sq   = sq * sq;
            rest = rest >> 1;
        end
        return acc;
    endfunction

    // Only the first error of an expression is kept.
    task automatic record_error(input logic [pfe_pkg::STATUS_W-1:0] code);
        if (shadow_error == pfe_pkg::ST_OK)
            shadow_error = code;
    endtask

    // Advances the shadow stack by one accepted character and, on the last character of
    // an expression, queues the result that the block must give.
    task automatic evaluate_symbol(input logic [pfe_pkg::SYM_W-1:0] sym, input logic last);
        logic [pfe_pkg::DATA_W-1:0] top;
        logic [pfe_pkg::DATA_W-1:0] below;
        logic [pfe_pkg::DATA_W-1:0] outcome;
        expr_result_t               res;
        if (is_operator(sym)) begin
            if (shadow_fill < 2) begin
                record_error(pfe_pkg::ST_UNDERFLOW);
            end else begin
                top   = shadow_stack[shadow_fill-1];
                below = shadow_stack[shadow_fill-2];
                case (sym)
                    pfe_pkg::CH_PLUS:  outcome = below + top;
                    pfe_pkg::CH_MINUS: outcome = below - top;
                    pfe_pkg::CH_STAR:  outcome = below * top;
                    pfe_pkg::CH_SLASH: begin
                        if (top == 0) begin
                            record_error(pfe_pkg::ST_DIVZERO);
                            outcome = 32'd0;
                        end else begin
                            outcome = quotient_trunc(below, top);
                        end
                    end
                    default:  outcome = power_wrap(below, top);
                endcase
                shadow_fill = shadow_fill - 1;
                shadow_stack[shadow_fill-1] = outcome;
            end
        end else if (is_digit(sym)) begin
            if (shadow_fill >= pfe_pkg::STACK_DEPTH) begin
                record_error(pfe_pkg::ST_OVERFLOW);
            end else begin
                shadow_stack[shadow_fill] = pfe_pkg::DATA_W'(sym - pfe_pkg::CH_ZERO);
                shadow_fill = shadow_fill + 1;
            end
        end
        if (last) begin
            res.value = (shadow_fill > 0) ? shadow_stack[shadow_fill-1] : '0;
            if (shadow_error != pfe_pkg::ST_OK)
                res.status = shadow_error;
            else if (shadow_fill == 0)
                res.status = pfe_pkg::ST_EMPTY;
            else
                res.status = pfe_pkg::ST_OK;
            pending_results.push_back(res);
            shadow_fill  = 0;
            shadow_error = pfe_pkg::ST_OK;
        end
    endtask

    // ------------------------------------------------------------------
    // Sender, receiver and result checker
    // ------------------------------------------------------------------

    // Offers one character. The idle gap, if any, is taken with valid low; once valid
    // rises it stays high with a steady payload until the transaction completes. The
    // predictor is advanced at the very edge that accepts the transaction.
    task automatic send_symbol(input logic [pfe_pkg::SYM_W-1:0] sym, input logic last);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_symbol      = sym;
        s_end_of_expr = last;
        do
            @(posedge aclk);
        while (!s_ready);
        evaluate_symbol(sym, last);
        symbols_sent++;
    endtask

    // Sends a written expression; its final character carries the end marker.
    task automatic send_text(input string expr);
        for (int i = 0; i < expr.len(); i++)
            send_symbol(expr[i], i == expr.len() - 1);
    endtask

    // Holds the sender back until every queued result has been taken.
    task automatic wait_results_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic report_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endtask

    // The receiver stalls at random, at the rate of the current phase.
    always @(negedge aclk) begin
        m_ready = ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Every accepted result is checked against the oldest expectation.
    always @(posedge aclk) begin
        expr_result_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (m_status < 5)
                status_seen[m_status]++;
            if (pending_results.size() == 0) begin
                report_failure($sformatf("%0t: unexpected result value=%0d status=%0d",
                                         $realtime, m_value, m_status));
            end else begin
                exp_res = pending_results.pop_front();
                if (m_value !== exp_res.value || m_status !== exp_res.status)
                    report_failure($sformatf(
                        "%0t: result mismatch: expected value=%0d status=%0d, %s",
                        $realtime, exp_res.value, exp_res.status,
                        $sformatf("got value=%0d status=%0d", m_value, m_status)));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus generators
    // ------------------------------------------------------------------

    function automatic logic [pfe_pkg::SYM_W-1:0] random_digit();
        return pfe_pkg::CH_ZERO + pfe_pkg::SYM_W'($urandom_range(0, 9));
    endfunction

    function automatic logic [pfe_pkg::SYM_W-1:0] random_operator();
        case ($urandom_range(0, 4))
            0:       return pfe_pkg::CH_PLUS;
            1:       return pfe_pkg::CH_MINUS;
            2:       return pfe_pkg::CH_STAR;
            3:       return pfe_pkg::CH_SLASH;
            default: return pfe_pkg::CH_CARET;
        endcase
    endfunction

    // Any byte that the evaluator skips over.
    function automatic logic [pfe_pkg::SYM_W-1:0] random_ignored();
        logic [pfe_pkg::SYM_W-1:0] c;
        do
            c = pfe_pkg::SYM_W'($urandom_range(0, 255));
        while (is_digit(c) || is_operator(c));
        return c;
    endfunction

    // Builds one expression and sends it. Most are well formed, with ignored bytes
    // scattered through them; a few push past the stack depth; the rest are random
    // jumbles that provoke underflow and leave odd values on the stack.
    task automatic send_random_expr();
        logic [pfe_pkg::SYM_W-1:0] seq [$];
        int digits_left;
        int depth;
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 14) begin
            repeat ($urandom_range(1, 10)) begin
                case ($urandom_range(0, 2))
                    0:       seq.push_back(random_digit());
                    1:       seq.push_back(random_operator());
                    default: seq.push_back(random_ignored());
                endcase
            end
        end else begin
            digits_left = (kind < 19) ? $urandom_range(16, 19) : $urandom_range(1, 7);
            depth       = 0;
            while (digits_left > 0 || depth > 1) begin
                if ($urandom_range(0, 7) == 0)
                    seq.push_back(random_ignored());
                if (digits_left > 0 && (depth < 2 || $urandom_range(0, 1) == 0)) begin
                    seq.push_back(random_digit());
                    digits_left--;
                    depth++;
                end else begin
                    seq.push_back(random_operator());
                    depth--;
                end
            end
            if ($urandom_range(0, 9) == 0)
                seq.push_back(random_ignored());
        end
        foreach (seq[i])
            send_symbol(seq[i], i == seq.size() - 1);
    endtask

    // ------------------------------------------------------------------
    // Test tasks
    // ------------------------------------------------------------------

    // Bytes at both ends of the range are skipped, and an expression with nothing on the
    // stack reports an empty stack with a zero value.
    task automatic test_empty_and_ignored();
        send_symbol(8'h00, 1'b0);
        send_symbol(8'hFF, 1'b1);
    endtask

    // An operator with too few operands, then a digit on a full stack: the seventeenth
    // digit is dropped, so the top stays at the sixteenth.
    task automatic test_stack_limits();
        send_text("+");
        send_text("01234567890123456");
    endtask

    // Two to the thirty-first wraps to the most negative value, which divided by minus one
    // wraps again. Seven over minus two truncates towards zero. A divide by zero pushes
    // zero, and the underflow that follows does not replace the first error.
    task automatic test_arithmetic_edges();
        send_text("284*1-^01-/");
        send_text("702-/");
        send_text("40/+");
    endtask

    // Negative exponents with the bases one, minus one and two, and zero to the zero.
    task automatic test_power_exponents();
        send_text("101-^01-03-^+");
        send_text("203-^00^+");
    endtask

    // Random expressions under one pair of idle and stall rates.
    task automatic test_random_expressions(input int idle_pct, input int stall_pct,
                                           input int count);
        int start;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start          = symbols_sent;
        while (symbols_sent - start < count)
            send_random_expr();
        // The sender waits here until the block has handed over every result.
        wait_results_drained();
    endtask

    // ------------------------------------------------------------------
    // Run sequence
    // ------------------------------------------------------------------

    initial begin
        aclk           = 1'b0;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_symbol       = '0;
        s_end_of_expr  = 1'b0;
        m_ready        = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        symbols_sent   = 0;
        results_seen   = 0;
        fail_count     = 0;
        shadow_fill    = 0;
        shadow_error   = pfe_pkg::ST_OK;
        foreach (status_seen[i])
            status_seen[i] = 0;
        foreach (shadow_stack[i])
            shadow_stack[i] = '0;

        // Reset is held low and then released on a falling edge.
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        // The directed cases run with light idling on both sides.
        send_idle_pct  = 12;
        recv_stall_pct = 12;
        test_empty_and_ignored();
        test_stack_limits();
        test_arithmetic_edges();
        test_power_exponents();
        wait_results_drained();

        // Random expressions: no idling, a slow sender, a slow receiver, then both.
        test_random_expressions(0, 0, 250);
        test_random_expressions(75, 0, 250);
        test_random_expressions(0, 75, 250);
        test_random_expressions(12, 12, 240);

        // Any stray result would arrive within one worst-case operation.
        repeat (80) @(posedge aclk);

        $display("Covered %0d characters in %0d checked results.",
                 symbols_sent, results_seen);
        $display("Statuses seen: ok %0d, underflow %0d, overflow %0d, %s",
                 status_seen[0], status_seen[1], status_seen[2],
                 $sformatf("divide by zero %0d, empty %0d.", status_seen[3],
                           status_seen[4]));
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("tb_postfix_expression_evaluator_top: PASS");
        end else begin
            $display("%0d failures, %0d results never arrived", fail_count,
                     pending_results.size());
            $display("tb_postfix_expression_evaluator_top: FAIL");
        end
        $finish;
    end

    // A hung handshake ends the run well beyond the slowest correct one.
    initial begin
        #8_000_000;
        $display("Timed out with %0d results still pending", pending_results.size());
        $display("tb_postfix_expression_evaluator_top: FAIL");
        $finish;
    end

endmodule

// ===== postfix_expression_evaluator_top.f =====
rtl/pfe_pkg.sv
rtl/pfe_datapath.sv
rtl/pfe_ctrl.sv
rtl/postfix_expression_evaluator_top.sv
bench/tb_postfix_expression_evaluator_top.sv
